/* rtl/efsd_pkg.sv */
// Package: widths, result kind codes and controller/datapath command and status types.
package efsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

    localparam int CFG_W       = 5;
    localparam int ARR_W       = 32;
    localparam int SVC_W       = 16;
    localparam int JOB_W       = 16;
    localparam int SRV_W       = 4;
    localparam int LOAD_W      = 32;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic emit_assign;
        logic emit_dump;
    } dsp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic dump_last;
        logic job_last;
        logic out_free;
    } dsp_status_t;

endpackage

/* rtl/efsd_job_if.sv */
// Job channel: valid/ready handshake with the job fields.
interface efsd_job_if;
    import efsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ARR_W-1:0] arrival_time;
    logic [SVC_W-1:0] service_time;
    logic [JOB_W-1:0] job_id;
    logic             last_job;

    modport source (output valid, arrival_time, service_time, job_id, last_job, input ready);
    modport sink   (input valid, arrival_time, service_time, job_id, last_job, output ready);
endinterface

/* rtl/efsd_result_if.sv */
// Result channel: valid/ready handshake with the assignment and dump fields.
interface efsd_result_if;
    import efsd_pkg::*;

    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [SRV_W-1:0]  server_index;
    logic [LOAD_W-1:0] finish_time;
    logic [JOB_W-1:0]  assigned_job;
    logic              last_result;

    modport source (output valid, result_kind, server_index, finish_time, assigned_job,
                    last_result, input ready);
    modport sink   (input valid, result_kind, server_index, finish_time, assigned_job,
                    last_result, output ready);
endinterface

/* rtl/efsd_datapath.sv */
// Datapath: server loads, min-load scan, finish time update, dump and output register.
module efsd_datapath import efsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic [ARR_W-1:0]  in_arrival,
    input  logic [SVC_W-1:0]  in_service,
    input  logic [JOB_W-1:0]  in_job,
    input  logic              in_last,
    input  dsp_cmd_t          cmd,
    output dsp_status_t       status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kind,
    output logic [SRV_W-1:0]  out_index,
    output logic [LOAD_W-1:0] out_finish,
    output logic [JOB_W-1:0]  out_job,
    output logic              out_last
);

    logic [CFG_W-1:0]  cfg_reg;
    logic [LOAD_W-1:0] load_reg [MAX_SERVERS];

    logic [ARR_W-1:0]  arrival_reg;
    logic [SVC_W-1:0]  service_reg;
    logic [JOB_W-1:0]  job_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [LOAD_W-1:0] best_load_reg;

    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [SRV_W-1:0]  out_index_reg;
    logic [LOAD_W-1:0] out_finish_reg;
    logic [JOB_W-1:0]  out_job_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  eff_count;
    logic [LOAD_W-1:0] load_rd;
    logic [LOAD_W-1:0] start_time;
    logic [LOAD_W:0]   fin_sum;
    logic [LOAD_W-1:0] fin_time;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_SERVERS))
        begin
            eff_count = CNT_W'(MAX_SERVERS);
        end
        else
        begin
            eff_count = CNT_W'(cfg_reg);
        end
    end

    assign load_rd    = load_reg[scan_idx_reg[IDX_W-1:0]];
    assign start_time = (best_load_reg > LOAD_W'(arrival_reg)) ? best_load_reg
                                                              : LOAD_W'(arrival_reg);
    assign fin_sum    = {1'b0, start_time} + (LOAD_W+1)'(service_reg);
    assign fin_time   = fin_sum[LOAD_W] ? '1 : fin_sum[LOAD_W-1:0];

    assign status.scan_done = (scan_idx_reg == n_reg);
    assign status.dump_last = (scan_idx_reg == n_reg - CNT_W'(1));
    assign status.job_last  = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (cmd.emit_dump && status.dump_last)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else if (cmd.emit_assign)
        begin
            load_reg[best_idx_reg] <= fin_time;
        end
    end

    // job latch and min-load scan
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            arrival_reg   <= in_arrival;
            service_reg   <= in_service;
            job_reg       <= in_job;
            last_reg      <= in_last;
            n_reg         <= eff_count;
            best_idx_reg  <= '0;
            best_load_reg <= load_reg[0];
            scan_idx_reg  <= CNT_W'(1);
        end
        else if (cmd.scan_step)
        begin
            if (load_rd < best_load_reg)
            begin
                best_idx_reg  <= scan_idx_reg[IDX_W-1:0];
                best_load_reg <= load_rd;
            end
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
        else if (cmd.emit_assign)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.emit_dump)
        begin
            scan_idx_reg <= scan_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_assign || cmd.emit_dump)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_assign)
        begin
            out_kind_reg   <= KIND_ASSIGN;
            out_index_reg  <= SRV_W'(best_idx_reg);
            out_finish_reg <= fin_time;
            out_job_reg    <= job_reg;
            out_last_reg   <= !last_reg;
        end
        else if (cmd.emit_dump)
        begin
            out_kind_reg   <= KIND_DUMP;
            out_index_reg  <= SRV_W'(scan_idx_reg);
            out_finish_reg <= load_rd;
            out_job_reg    <= '0;
            out_last_reg   <= status.dump_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_index  = out_index_reg;
    assign out_finish = out_finish_reg;
    assign out_job    = out_job_reg;
    assign out_last   = out_last_reg;

endmodule

/* rtl/efsd_ctrl.sv */
// Controller: sequences job accept, load scan, assignment and final dump.
module efsd_ctrl import efsd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dsp_status_t status,
    output dsp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DUMP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_UPD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_assign = 1'b1;
                    state_next      = status.job_last ? ST_DUMP : ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (status.out_free)
                begin
                    cmd.emit_dump = 1'b1;
                    if (status.dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/earliest_free_server_dispatch_top.sv */
// Top level: earliest-free-server job dispatcher.
//
//  channel   dir  payload                                                     handshake
//  jobs      in   arrival_time, service_time, job_id, last_job                valid/ready
//  results   out  result_kind, server_index, finish_time, assigned_job,       valid/ready
//                 last_result
//  cfg       in   cfg_wr_data (active_servers)                                cfg_wr_en
//
//  With n active servers, the scan compares one load per cycle against the best so far.
//  A last job adds a dump of one result per active server; loads clear on the final one.
//  Reset: loads zero, active_servers = 16, no result pending.
//  A stalled result holds the update and dump; the next job is taken while a result waits.
module earliest_free_server_dispatch_top import efsd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    efsd_job_if.sink         jobs,
    efsd_result_if.source    results
);

    dsp_cmd_t    cmd;
    dsp_status_t status;
    logic        ctl_ready;

    efsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (jobs.valid),
        .in_ready (ctl_ready),
        .status   (status),
        .cmd      (cmd)
    );

    efsd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_arrival  (jobs.arrival_time),
        .in_service  (jobs.service_time),
        .in_job      (jobs.job_id),
        .in_last     (jobs.last_job),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .out_kind    (results.result_kind),
        .out_index   (results.server_index),
        .out_finish  (results.finish_time),
        .out_job     (results.assigned_job),
        .out_last    (results.last_result)
    );

    assign jobs.ready = ctl_ready;

`ifndef SYNTH
    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_assign || cmd.emit_dump) |-> status.out_free)
        else $error("result emitted while output register busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !jobs.ready)
        else $error("job accepted during scan");

    a_dump_end_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_dump && status.dump_last) |=> (results.valid && results.last_result))
        else $error("final dump item not flagged last");
`endif

endmodule

/* test/earliest_free_server_dispatch_top_tb.sv */
// Testbench for earliest_free_server_dispatch_top: directed and random job batches.
module earliest_free_server_dispatch_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efsd_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 2 * MAX_SERVERS + 8;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 33;

    typedef struct packed {
        logic              kind;
        logic [SRV_W-1:0]  server;
        logic [LOAD_W-1:0] finish;
        logic [JOB_W-1:0]  job;
        logic              last;
    } result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    efsd_job_if    job_ch ();
    efsd_result_if res_ch ();

    earliest_free_server_dispatch_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .jobs       (job_ch.sink),
        .results    (res_ch.source)
    );

    logic [LOAD_W-1:0] center_load [MAX_SERVERS];
    logic [CFG_W-1:0]  active_servers_cfg;
    result_t           due_results [$];
    result_t           got_result;
    result_t           want_result;
    int unsigned       mismatch_cnt = 0;
    int unsigned       cycle_cnt = 0;
    bit                idle_gaps;
    bit                hold_pending;
    logic [JOB_W-1:0]  next_id;
    logic [ARR_W-1:0]  arrival_cursor;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[earliest_free_server_dispatch_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned effective_servers();
        int unsigned n;
        n = 32'(active_servers_cfg);
        if (n == 0)
            n = 1;
        if (n > MAX_SERVERS)
            n = MAX_SERVERS;
        return n;
    endfunction

    // earliest completion wins, ties to the lowest index; last job dumps and clears
    task automatic schedule_job(input logic [ARR_W-1:0] arrival, input logic [SVC_W-1:0] service,
                                input logic [JOB_W-1:0] id, input logic last);
        int unsigned       n;
        int unsigned       best;
        logic [LOAD_W-1:0] start;
        logic [LOAD_W:0]   sum;
        result_t           r;
        n = effective_servers();
        best = 0;
        for (int unsigned i = 1; i < n; i++)
            if (center_load[i] < center_load[best])
                best = i;
        start = (center_load[best] > arrival) ? center_load[best] : arrival;
        sum = {1'b0, start} + {{(LOAD_W + 1 - SVC_W){1'b0}}, service};
        center_load[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        r.kind   = KIND_ASSIGN;
        r.server = SRV_W'(best);
        r.finish = center_load[best];
        r.job    = id;
        r.last   = ~last;
        due_results.push_back(r);
        if (last)
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                r.kind   = KIND_DUMP;
                r.server = SRV_W'(i);
                r.finish = center_load[i];
                r.job    = '0;
                r.last   = (i + 1 == n);
                due_results.push_back(r);
            end
            foreach (center_load[i])
                center_load[i] = '0;
        end
    endtask

    task automatic send_job(input logic [ARR_W-1:0] arrival, input logic [SVC_W-1:0] service,
                            input logic [JOB_W-1:0] id, input logic last);
        int unsigned gap;
        if (idle_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            job_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_ch.valid        <= 1'b1;
        job_ch.arrival_time <= arrival;
        job_ch.service_time <= service;
        job_ch.job_id       <= id;
        job_ch.last_job     <= last;
        @(posedge clk);
        while (!job_ch.ready)
            @(posedge clk);
        schedule_job(arrival, service, id, last);
    endtask

    task automatic wait_idle();
        job_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        active_servers_cfg = value;
    endtask

    // mostly sorted arrivals from a moving cursor, some unsorted or misplaced last flags
    task automatic send_batch(input int unsigned len);
        logic [ARR_W-1:0] arrival;
        logic [SVC_W-1:0] service;
        logic [JOB_W-1:0] id;
        logic             last;
        case ($urandom_range(0, 5))
            0:       arrival_cursor = '0;
            1:       arrival_cursor = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
            2:       arrival_cursor = $urandom;
            default: arrival_cursor = arrival_cursor + $urandom_range(0, 2000);
        endcase
        for (int unsigned k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                arrival = $urandom;
            else
            begin
                arrival_cursor = arrival_cursor + $urandom_range(0, 400);
                arrival = arrival_cursor;
            end
            if ($urandom_range(0, 5) == 0)
                service = SVC_W'($urandom_range(0, 16'hFFFF));
            else
                service = SVC_W'($urandom_range(0, 600));
            if ($urandom_range(0, 7) == 0)
                id = JOB_W'($urandom);
            else
            begin
                next_id = next_id + JOB_W'(1);
                id = next_id;
            end
            last = (k + 1 == len) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
            send_job(arrival, service, id, last);
        end
    endtask

    task automatic test_reset_state();
        send_job(32'd0, 16'd0, 16'd0, 1'b0);
        send_job(32'd0, 16'd5, 16'd1, 1'b0);
        send_job(32'd0, 16'd0, 16'd2, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_job(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_job(32'hFFFF_FFF0, 16'h0010, 16'h0000, 1'b0);
        send_job(32'hFFFF_FFF0, 16'h000F, 16'hAAAA, 1'b0);
        send_job(32'h5555_5555, 16'h5555, 16'h5555, 1'b0);
        send_job(32'hAAAA_AAAA, 16'hAAAA, 16'hAAAA, 1'b1);
    endtask

    // zero acts as one center, counts above the maximum act as the maximum
    task automatic test_active_count_limits();
        write_active(5'd0);
        send_job(32'd10, 16'd20, 16'd3, 1'b0);
        send_job(32'd15, 16'd20, 16'd4, 1'b1);
        write_active(5'd31);
        send_job(32'd0, 16'd7, 16'd5, 1'b0);
        send_job(32'd1, 16'd7, 16'd6, 1'b1);
        write_active(5'd1);
        send_job(32'd100, 16'd1, 16'd7, 1'b0);
        send_job(32'd100, 16'd1, 16'd8, 1'b1);
        write_active(5'd17);
        send_job(32'd3, 16'd9, 16'd9, 1'b1);
    endtask

    task automatic test_unsorted_arrivals();
        write_active(5'd4);
        send_job(32'd1000, 16'd50, 16'd20, 1'b0);
        send_job(32'd10, 16'd30, 16'd19, 1'b0);
        send_job(32'd500, 16'd0, 16'd21, 1'b0);
        send_job(32'd0, 16'd200, 16'd18, 1'b1);
    endtask

    task automatic test_backpressure();
        write_active(5'd3);
        hold_pending = 1'b1;
        for (int unsigned k = 0; k < 16; k++)
            send_job(32'(k * 10), 16'd50, 16'(100 + k), (k % 5) == 4);
        wait_idle();
    endtask

    task automatic test_random_batches();
        logic [CFG_W-1:0] setting [7];
        int unsigned      sent;
        int unsigned      len;
        setting = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd0, 5'd12, 5'd0};
        setting[6] = CFG_W'($urandom_range(0, 31));
        for (int p = 0; p < 7; p++)
        begin
            write_active(setting[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = $urandom_range(1, 16);
                send_batch(len);
                sent += len;
            end
        end
    endtask

    task automatic test_quiet_tail();
        int unsigned sent;
        int unsigned len;
        write_active(CFG_W'($urandom_range(1, 16)));
        idle_gaps = 1'b0;
        sent = 0;
        while (sent < 40)
        begin
            len = $urandom_range(1, 12);
            send_batch(len);
            sent += len;
        end
    endtask

    initial
    begin : result_ready_ctl
        int unsigned stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            else if (idle_gaps && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 9);
            else
                stall = 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got_result = '{res_ch.result_kind, res_ch.server_index, res_ch.finish_time,
                           res_ch.assigned_job, res_ch.last_result};
            if (due_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result: kind %0d server %0d finish %h job %h last %0d",
                             got_result.kind, got_result.server, got_result.finish,
                             got_result.job, got_result.last);
            end
            else
            begin
                want_result = due_results.pop_front();
                if (got_result !== want_result)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"result mismatch: want kind %0d server %0d finish %h job %h ",
                                  "last %0d, got kind %0d server %0d finish %h job %h last %0d"},
                                 want_result.kind, want_result.server, want_result.finish,
                                 want_result.job, want_result.last,
                                 got_result.kind, got_result.server, got_result.finish,
                                 got_result.job, got_result.last);
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        job_ch.valid        = 1'b0;
        job_ch.arrival_time = '0;
        job_ch.service_time = '0;
        job_ch.job_id       = '0;
        job_ch.last_job     = 1'b0;
        idle_gaps           = 1'b1;
        hold_pending        = 1'b0;
        next_id             = 16'd1000;
        arrival_cursor      = '0;
        active_servers_cfg  = ACTIVE_RESET;
        foreach (center_load[i])
            center_load[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_field_extremes();
        test_active_count_limits();
        test_unsorted_arrivals();
        test_backpressure();
        test_random_batches();
        test_quiet_tail();
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[earliest_free_server_dispatch_top] OK");
        else
            $display("[earliest_free_server_dispatch_top] ERROR");
        $finish;
    end

endmodule
